@@ hdl/b2r_pkg.sv @@
// Shared types, constants and numeral tables for the binary to Roman numeral encoder.
package b2r_pkg;

  localparam int unsigned NumW     = 12;
  localparam int unsigned CharW    = 8;
  localparam int unsigned NumPairs = 13;
  localparam int unsigned PairIdxW = $clog2(NumPairs);

  localparam logic [CharW-1:0] ChNone = 8'h00;
  localparam logic [CharW-1:0] ChM    = 8'h4D;
  localparam logic [CharW-1:0] ChD    = 8'h44;
  localparam logic [CharW-1:0] ChC    = 8'h43;
  localparam logic [CharW-1:0] ChL    = 8'h4C;
  localparam logic [CharW-1:0] ChX    = 8'h58;
  localparam logic [CharW-1:0] ChV    = 8'h56;
  localparam logic [CharW-1:0] ChI    = 8'h49;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_first;
    logic emit_second;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_zero;
    logic two_letter;
    logic rest_zero;
  } stat_t;

  function automatic logic [NumW-1:0] pair_value(input logic [PairIdxW-1:0] idx);
    logic [NumW-1:0] v;
    unique case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [CharW-1:0] pair_first(input logic [PairIdxW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      4'd0:    c = ChM;
      4'd1:    c = ChC;
      4'd2:    c = ChD;
      4'd3:    c = ChC;
      4'd4:    c = ChC;
      4'd5:    c = ChX;
      4'd6:    c = ChL;
      4'd7:    c = ChX;
      4'd8:    c = ChX;
      4'd9:    c = ChI;
      4'd10:   c = ChV;
      default: c = ChI;
    endcase
    return c;
  endfunction

  // A pair with a single letter returns ChNone here.
  function automatic logic [CharW-1:0] pair_second(input logic [PairIdxW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      4'd11:   c = ChV;
      default: c = ChNone;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/binary_to_roman_numeral_encoder.sv @@
// Top level of the binary to Roman numeral encoder.
//
// Usage: drive number_i and raise start while busy is low; the number is
// taken at that clock edge and busy rises in the next cycle. The numeral
// then leaves as one beat per letter, most significant letter first, each
// beat on char_code_o for exactly one cycle while strobe_o is high. The
// final beat has is_last_o set. Input zero gives a single beat with
// no_char_o and is_last_o set and char_code_o zero.
// The accepting edge moves the controller to its first-letter state, and
// that state's letter is then registered into the output beat registers.
// Letters follow one per cycle from the greedy pair selection and
// subtract; the block stays busy until its final letter, so a new number
// is accepted only once the previous numeral is through.
// The receiver cannot stall; beats are never held back.
// Reset clears the controller and the beat strobe; the block then waits
// for start.
module binary_to_roman_numeral_encoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [b2r_pkg::NumW-1:0]  number_i,
  output logic                      strobe_o,
  output logic [b2r_pkg::CharW-1:0] char_code_o,
  output logic                      no_char_o,
  output logic                      is_last_o
);

  b2r_pkg::cmd_t  cmd;
  b2r_pkg::stat_t stat;

  b2r_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  b2r_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (number_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .strobe_o    (strobe_o),
    .char_code_o (char_code_o),
    .no_char_o   (no_char_o),
    .is_last_o   (is_last_o)
  );

  // An accepted number always occupies the block in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted number did not make the block busy");

  // The block goes idle exactly when the final beat is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> strobe_o && is_last_o)
    else $error("block went idle without a final beat");

  // A beat that is not the last one means more letters are still to come.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !is_last_o |-> busy)
    else $error("non-final beat while idle");

  // The empty result for zero is always a single, final beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && no_char_o |-> is_last_o && (char_code_o == b2r_pkg::ChNone))
    else $error("empty beat is not final or carries a letter");

endmodule

@@ hdl/b2r_ctrl.sv @@
// Controller state machine that sequences the letters of one numeral.
module b2r_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  b2r_pkg::stat_t stat_i,
  output b2r_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StFirst  = 2'd1;
  localparam logic [1:0] StSecond = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d           = state_q;
    cmd_o.load        = 1'b0;
    cmd_o.emit_first  = 1'b0;
    cmd_o.emit_second = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StFirst;
        end
      end
      StFirst: begin
        cmd_o.emit_first = 1'b1;
        if (stat_i.is_zero || (!stat_i.two_letter && stat_i.rest_zero)) begin
          state_d = StIdle;
        end else if (stat_i.two_letter) begin
          state_d = StSecond;
        end
      end
      StSecond: begin
        cmd_o.emit_second = 1'b1;
        state_d = stat_i.rest_zero ? StIdle : StFirst;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

@@ hdl/b2r_dpath.sv @@
// Datapath: remaining value, greedy pair selection and the registered output beat.
module b2r_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [b2r_pkg::NumW-1:0]     number_i,
  input  b2r_pkg::cmd_t                cmd_i,
  output b2r_pkg::stat_t               stat_o,
  output logic                         strobe_o,
  output logic [b2r_pkg::CharW-1:0]    char_code_o,
  output logic                         no_char_o,
  output logic                         is_last_o
);

  logic [b2r_pkg::NumW-1:0]     rest_q, rest_d, diff;
  logic [b2r_pkg::PairIdxW-1:0] idx_q, idx_d, sel, sub_idx;
  logic                         strobe_q;
  logic [b2r_pkg::CharW-1:0]    char_q, char_d;
  logic                         nochar_q, nochar_d, last_q, last_d;
  logic                         two_letter;

  // Largest table value that still fits: the lowest index whose value is not above rest.
  always_comb begin
    sel = b2r_pkg::PairIdxW'(b2r_pkg::NumPairs - 1);
    for (int p = b2r_pkg::NumPairs - 1; p >= 0; p--) begin
      if (rest_q >= b2r_pkg::pair_value(b2r_pkg::PairIdxW'(p))) begin
        sel = b2r_pkg::PairIdxW'(p);
      end
    end
  end

  assign two_letter = (b2r_pkg::pair_second(sel) != b2r_pkg::ChNone);
  assign sub_idx    = cmd_i.emit_second ? idx_q : sel;
  assign diff       = rest_q - b2r_pkg::pair_value(sub_idx);

  assign stat_o.is_zero    = (rest_q == '0);
  assign stat_o.two_letter = two_letter;
  assign stat_o.rest_zero  = (diff == '0);

  always_comb begin
    rest_d   = rest_q;
    idx_d    = idx_q;
    char_d   = char_q;
    nochar_d = nochar_q;
    last_d   = last_q;
    if (cmd_i.load) begin
      rest_d = number_i;
    end else if (cmd_i.emit_first) begin
      idx_d = sel;
      if (rest_q == '0) begin
        char_d   = b2r_pkg::ChNone;
        nochar_d = 1'b1;
        last_d   = 1'b1;
      end else begin
        char_d   = b2r_pkg::pair_first(sel);
        nochar_d = 1'b0;
        last_d   = !two_letter && (diff == '0);
        // A two-letter pair subtracts its value with the second letter.
        if (!two_letter) begin
          rest_d = diff;
        end
      end
    end else if (cmd_i.emit_second) begin
      char_d   = b2r_pkg::pair_second(idx_q);
      nochar_d = 1'b0;
      last_d   = (diff == '0);
      rest_d   = diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_first | cmd_i.emit_second;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    idx_q    <= idx_d;
    char_q   <= char_d;
    nochar_q <= nochar_d;
    last_q   <= last_d;
  end

  assign strobe_o    = strobe_q;
  assign char_code_o = char_q;
  assign no_char_o   = nochar_q;
  assign is_last_o   = last_q;

endmodule

@@ dv/binary_to_roman_numeral_encoder_tb.sv @@
// Self-checking testbench for the binary to Roman numeral encoder.
module binary_to_roman_numeral_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumDirected = 24;
  localparam int unsigned NumRandom   = 396;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 24;

  typedef struct {
    logic [b2r_pkg::CharW-1:0] code;
    logic                      none;
    logic                      last;
  } letter_t;

  typedef struct packed {
    logic [b2r_pkg::NumW-1:0]  value;
    logic [b2r_pkg::CharW-1:0] head;
    logic [b2r_pkg::CharW-1:0] tail;
  } numeral_step_t;

  // A typed row with an empty numeral stands for the single no-letter beat of zero.
  typedef struct {
    logic [b2r_pkg::NumW-1:0] num;
    bit                       typed;
    string                    numeral;
  } directed_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [b2r_pkg::NumW-1:0]  number_i;
  logic                      strobe_o;
  logic [b2r_pkg::CharW-1:0] char_code_o;
  logic                      no_char_o;
  logic                      is_last_o;

  letter_t           letters_due[$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  bit                burst_mode = 1'b0;

  directed_row_t directed_rows [NumDirected] = '{
    '{12'd0,    1'b1, ""},
    '{12'd1,    1'b1, "I"},
    '{12'd4095, 1'b1, "MMMMXCV"},
    '{12'd3888, 1'b1, "MMMDCCCLXXXVIII"},
    '{12'd4000, 1'b1, "MMMM"},
    '{12'd3999, 1'b1, "MMMCMXCIX"},
    '{12'd4,    1'b0, ""},
    '{12'd9,    1'b0, ""},
    '{12'd40,   1'b0, ""},
    '{12'd90,   1'b0, ""},
    '{12'd400,  1'b0, ""},
    '{12'd900,  1'b0, ""},
    '{12'd5,    1'b0, ""},
    '{12'd50,   1'b0, ""},
    '{12'd500,  1'b0, ""},
    '{12'd1000, 1'b0, ""},
    '{12'd2048, 1'b0, ""},
    '{12'd1365, 1'b0, ""},
    '{12'd2730, 1'b0, ""},
    '{12'd14,   1'b0, ""},
    '{12'd49,   1'b0, ""},
    '{12'd944,  1'b0, ""},
    '{12'd1994, 1'b0, ""},
    '{12'd3000, 1'b0, ""}
  };

  binary_to_roman_numeral_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .number_i    (number_i),
    .strobe_o    (strobe_o),
    .char_code_o (char_code_o),
    .no_char_o   (no_char_o),
    .is_last_o   (is_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic numeral_step_t numeral_step(input int idx);
    numeral_step_t s;
    case (idx)
      0:       s = '{12'd1000, b2r_pkg::ChM, b2r_pkg::ChNone};
      1:       s = '{12'd900,  b2r_pkg::ChC, b2r_pkg::ChM};
      2:       s = '{12'd500,  b2r_pkg::ChD, b2r_pkg::ChNone};
      3:       s = '{12'd400,  b2r_pkg::ChC, b2r_pkg::ChD};
      4:       s = '{12'd100,  b2r_pkg::ChC, b2r_pkg::ChNone};
      5:       s = '{12'd90,   b2r_pkg::ChX, b2r_pkg::ChC};
      6:       s = '{12'd50,   b2r_pkg::ChL, b2r_pkg::ChNone};
      7:       s = '{12'd40,   b2r_pkg::ChX, b2r_pkg::ChL};
      8:       s = '{12'd10,   b2r_pkg::ChX, b2r_pkg::ChNone};
      9:       s = '{12'd9,    b2r_pkg::ChI, b2r_pkg::ChX};
      10:      s = '{12'd5,    b2r_pkg::ChV, b2r_pkg::ChNone};
      11:      s = '{12'd4,    b2r_pkg::ChI, b2r_pkg::ChV};
      default: s = '{12'd1,    b2r_pkg::ChI, b2r_pkg::ChNone};
    endcase
    return s;
  endfunction

  function automatic void push_letter(input logic [b2r_pkg::CharW-1:0] code);
    letter_t l;
    l.code = code;
    l.none = 1'b0;
    l.last = 1'b0;
    letters_due.push_back(l);
  endfunction

  function automatic void push_blank();
    letter_t l;
    l.code = b2r_pkg::ChNone;
    l.none = 1'b1;
    l.last = 1'b1;
    letters_due.push_back(l);
  endfunction

  // Greedy pass over the value/letter pairs, largest first.
  function automatic void expand_numeral(input logic [b2r_pkg::NumW-1:0] num);
    int unsigned   rest;
    numeral_step_t s;
    rest = num;
    if (rest == 0) begin
      push_blank();
      return;
    end
    for (int p = 0; p < int'(b2r_pkg::NumPairs); p++) begin
      s = numeral_step(p);
      while (rest >= s.value) begin
        push_letter(s.head);
        if (s.tail != b2r_pkg::ChNone) push_letter(s.tail);
        rest -= s.value;
      end
    end
    letters_due[letters_due.size()-1].last = 1'b1;
  endfunction

  function automatic void expand_literal(input string numeral);
    if (numeral.len() == 0) begin
      push_blank();
      return;
    end
    for (int i = 0; i < numeral.len(); i++) push_letter(numeral[i]);
    letters_due[letters_due.size()-1].last = 1'b1;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of uniform values, short numerals, long numerals and the range ends.
  function automatic logic [b2r_pkg::NumW-1:0] pick_number();
    int unsigned digits[4];
    int unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 4095);
      4:          v = $urandom_range(0, 30);
      5:          v = $urandom_range(3000, 4095);
      6, 7: begin
        foreach (digits[i]) digits[i] = ($urandom_range(0, 1) != 0) ? 8 : 3;
        if ($urandom_range(0, 2) == 0) digits[1] = 9;
        if ($urandom_range(0, 2) == 0) digits[3] = 4;
        v = $urandom_range(0, 3) * 1000 + digits[1] * 100 + digits[2] * 10 + digits[3];
      end
      8:          v = ($urandom_range(0, 1) != 0) ? 0 : 4095;
      default:    v = $urandom_range(0, 4095);
    endcase
    return v[b2r_pkg::NumW-1:0];
  endfunction

  // Holds start low for the gap, then offers the number until busy is low at an edge.
  task automatic offer_number(input logic [b2r_pkg::NumW-1:0] num, input int unsigned gap);
    if (gap != 0) begin
      start    <= 1'b0;
      number_i <= b2r_pkg::NumW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    number_i <= num;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input int exp_v, input int got_v);
    $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    letter_t want;
    if (rst_ni && strobe_o) begin
      if (letters_due.size() == 0) begin
        flag_mismatch("unexpected beat", 0, char_code_o);
      end else begin
        want = letters_due.pop_front();
        if (char_code_o !== want.code) flag_mismatch("char_code", want.code, char_code_o);
        if (no_char_o !== want.none) flag_mismatch("no_char", want.none, no_char_o);
        if (is_last_o !== want.last) flag_mismatch("is_last", want.last, is_last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("binary_to_roman_numeral_encoder verification failed");
      $finish;
    end
  end

  initial begin
    logic [b2r_pkg::NumW-1:0] num;
    rst_ni   = 1'b0;
    start    = 1'b0;
    number_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_number(directed_rows[i].num, gap_len());
      if (directed_rows[i].typed) expand_literal(directed_rows[i].numeral);
      else expand_numeral(directed_rows[i].num);
    end

    // Mix stretches of back-to-back numbers with stretches of random gaps, the mode picked at random every 40 numbers.
    for (int n = 0; n < int'(NumRandom); n++) begin
      if (n % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      num = pick_number();
      offer_number(num, gap_len());
      expand_numeral(num);
    end

    start <= 1'b0;
    while (letters_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("binary_to_roman_numeral_encoder verification clean");
    end else begin
      $display("binary_to_roman_numeral_encoder verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/b2r_pkg.sv
hdl/b2r_ctrl.sv
hdl/b2r_dpath.sv
hdl/binary_to_roman_numeral_encoder.sv
dv/binary_to_roman_numeral_encoder_tb.sv
